FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the active-low reset is asserted. Define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every rising edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true at a rising edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/lepe_pkg.sv
// ---------------------------------------------------------------------------
// lepe_pkg
// Types, field widths, codes and arithmetic helpers of the linear expression
// program evaluator.
// ---------------------------------------------------------------------------
package lepe_pkg;

	localparam int VALUE_W      = 48;
	localparam int FRAC_W       = 16;
	localparam int HALF_W       = VALUE_W / 2;
	localparam int PROD_W       = 2 * VALUE_W;
	localparam int CONST_W      = 18;
	localparam int CFG_IDX_W    = 2;
	localparam int KIND_W       = 2;
	localparam int CODE_W       = 4;
	localparam int VSLOT_W      = 4;
	localparam int SRC_W        = 6;
	localparam int GSLOT_W      = 6;

	localparam int PROG_LEN_DEF  = 64;
	localparam int VAR_COUNT_DEF = 16;

	typedef logic signed [VALUE_W-1:0]   value_t;
	typedef logic signed [VALUE_W:0]     wide_t;
	typedef logic signed [PROD_W-1:0]    prod_t;
	typedef logic signed [HALF_W:0]      half_t;
	typedef logic signed [2*HALF_W+1:0]  part_t;
	typedef logic signed [CONST_W-1:0]   const_t;

	localparam value_t Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam value_t Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Item function.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_GENE = 1'b1;

	// Gene kinds.
	localparam logic [KIND_W-1:0] KIND_OP    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VAR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CONST = 2'd2;

	// Operator codes.
	localparam logic [CODE_W-1:0] OP_ADD = 4'd0;
	localparam logic [CODE_W-1:0] OP_SUB = 4'd1;
	localparam logic [CODE_W-1:0] OP_MUL = 4'd2;
	localparam logic [CODE_W-1:0] OP_MAX = 4'd3;
	localparam logic [CODE_W-1:0] OP_MIN = 4'd4;

	// Register indexes; a constant gene selects the constant of the same index.
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CONST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CONST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THIRD_CONST  = 2'd2;

	// Clamp a sum or difference that carries one extra bit to the value range.
	function automatic value_t sat_value(input wide_t x);
		value_t r;
		if (x[VALUE_W] != x[VALUE_W-1]) begin
			r = x[VALUE_W] ? Q_MIN : Q_MAX;
		end else begin
			r = x[VALUE_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/linear_expression_program_evaluator.sv
// ---------------------------------------------------------------------------
// linear_expression_program_evaluator
// Runs a linear expression program one gene per transaction in signed Q31.16.
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle while results are taken; a gene
// that reads the slot of the gene right ahead of it waits until that
// value leaves the multiply-sum stage. Load transactions give no result.
// Reset clears the pipeline, the gene position and the constants; the
// slot store and the variable store are left as they are.
`include "assert_macros.svh"

module linear_expression_program_evaluator
	import lepe_pkg::*;
#(
	parameter int PROG_LEN  = PROG_LEN_DEF,
	parameter int VAR_COUNT = VAR_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CONST_W-1:0]          cfg_data,
	// Input items.
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic                        func,
	input  logic [VSLOT_W-1:0]          var_slot,
	input  logic signed [VALUE_W-1:0]   var_value,
	input  logic [KIND_W-1:0]           gene_kind,
	input  logic [CODE_W-1:0]           gene_code,
	input  logic [SRC_W-1:0]            src_a,
	input  logic [SRC_W-1:0]            src_b,
	input  logic                        last_gene,
	// Results.
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [VALUE_W-1:0]   gene_value,
	output logic [GSLOT_W-1:0]          gene_slot,
	output logic                        is_output
);

	localparam int SLOT_W = (PROG_LEN > 1) ? $clog2(PROG_LEN) : 1;
	localparam int VAR_W  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	// The three configured constants.
	const_t cfg_q [3];

	// Slot store and variable store: written at one address, read registered.
	value_t partial_q   [PROG_LEN];
	value_t var_store_q [VAR_COUNT];

	// Slot of the next gene.
	logic [SLOT_W-1:0] pos_q;

	// Stage 1: operands read from the stores, plus captured late writes.
	logic               vld_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic [CODE_W-1:0]  code_s1;
	logic               last_s1;
	logic [SLOT_W-1:0]  pos_s1;
	logic [SLOT_W-1:0]  addr_a_s1, addr_b_s1;
	logic               a_ok_s1, b_ok_s1, var_ok_s1;
	value_t             rda_s1, rdb_s1, var_rd_s1;
	logic               fwd_a_vld_s1, fwd_b_vld_s1;
	value_t             fwd_a_s1, fwd_b_s1;

	// Stage 2: selected value or the four partial products of a multiply.
	logic               vld_s2;
	logic               is_mul_s2;
	logic               last_s2;
	logic [SLOT_W-1:0]  pos_s2;
	value_t             val_s2;
	part_t              pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;

	// Result register.
	logic               out_vld_q;
	value_t             out_value_q;
	logic [GSLOT_W-1:0] out_slot_q;
	logic               out_last_q;

	// Handshake and pipeline control.
	logic               item_go, load_go, gene_go;
	logic               out_free, s2_go, s2_free, s1_go, hazard;

	// Input-side decode.
	logic               a_ok_in, b_ok_in, var_ok_in, vslot_ok_in;
	logic [SLOT_W-1:0]  addr_a_in, addr_b_in;

	// Stage 1 datapath.
	value_t             opa, opb, val_s1;
	wide_t              sum_s1, diff_s1;
	half_t              a_lo, a_hi, b_lo, b_hi;
	logic               is_mul_s1;

	// Stage 2 datapath and the slot write.
	prod_t              prod;
	logic [PROD_W-FRAC_W-VALUE_W:0] prod_top;
	value_t             mul_value;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_slot;
	value_t             wr_value;

	// -----------------------------------------------------------------------
	// Flow control. The result register frees stage 2, stage 2 frees stage 1,
	// and stage 1 frees the input. A gene in stage 1 whose operand slot is the
	// one still being computed in stage 2 is held until that value is written.
	// -----------------------------------------------------------------------
	assign out_free   = !out_vld_q || result_ready;
	assign s2_go      = vld_s2 && out_free;
	assign s2_free    = !vld_s2 || out_free;
	assign hazard     = vld_s1 && (kind_s1 == KIND_OP) && vld_s2 &&
	                    ((a_ok_s1 && (addr_a_s1 == pos_s2)) ||
	                     (b_ok_s1 && (addr_b_s1 == pos_s2)));
	assign s1_go      = vld_s1 && !hazard && s2_free;
	assign item_ready = !vld_s1 || s1_go;
	assign item_go    = item_valid && item_ready;
	assign load_go    = item_go && (func == FUNC_LOAD);
	assign gene_go    = item_go && (func == FUNC_GENE);

	// Slots beyond the program length read as zero, as do variables beyond
	// the store; a load to such a variable is dropped.
	assign a_ok_in     = int'(src_a) < PROG_LEN;
	assign b_ok_in     = int'(src_b) < PROG_LEN;
	assign addr_a_in   = SLOT_W'(src_a);
	assign addr_b_in   = SLOT_W'(src_b);
	assign var_ok_in   = int'(gene_code) < VAR_COUNT;
	assign vslot_ok_in = int'(var_slot) < VAR_COUNT;

	// -----------------------------------------------------------------------
	// Configuration registers.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= '0;
			cfg_q[1] <= '0;
			cfg_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_CONST:  cfg_q[0] <= cfg_data;
				CFG_SECOND_CONST: cfg_q[1] <= cfg_data;
				CFG_THIRD_CONST:  cfg_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Gene position. A last gene, or one in the last slot, wraps it to zero.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (gene_go) begin
			if (last_gene || (pos_q == SLOT_W'(PROG_LEN - 1))) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stores. Loads write the variable store as they are accepted, so a later
	// gene always reads the loaded value. Operand reads happen as a gene is
	// accepted; any slot write at that edge or while the gene waits in
	// stage 1 is captured separately below.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (load_go && vslot_ok_in) begin
			var_store_q[VAR_W'(var_slot)] <= var_value;
		end
		if (wr_en) begin
			partial_q[wr_slot] <= wr_value;
		end
		if (gene_go) begin
			rda_s1    <= partial_q[addr_a_in];
			rdb_s1    <= partial_q[addr_b_in];
			var_rd_s1 <= var_store_q[VAR_W'(gene_code)];
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1 registers.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			fwd_a_vld_s1 <= 1'b0;
			fwd_b_vld_s1 <= 1'b0;
		end else begin
			if (gene_go) begin
				vld_s1 <= 1'b1;
			end else if (s1_go) begin
				vld_s1 <= 1'b0;
			end

			if (gene_go) begin
				fwd_a_vld_s1 <= wr_en && (wr_slot == addr_a_in);
				fwd_b_vld_s1 <= wr_en && (wr_slot == addr_b_in);
			end else if (vld_s1 && !s1_go && wr_en) begin
				if (wr_slot == addr_a_s1) begin
					fwd_a_vld_s1 <= 1'b1;
				end
				if (wr_slot == addr_b_s1) begin
					fwd_b_vld_s1 <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gene_go) begin
			kind_s1   <= gene_kind;
			code_s1   <= gene_code;
			last_s1   <= last_gene;
			pos_s1    <= pos_q;
			addr_a_s1 <= addr_a_in;
			addr_b_s1 <= addr_b_in;
			a_ok_s1   <= a_ok_in;
			b_ok_s1   <= b_ok_in;
			var_ok_s1 <= var_ok_in;
			fwd_a_s1  <= wr_value;
			fwd_b_s1  <= wr_value;
		end else if (vld_s1 && !s1_go && wr_en) begin
			if (wr_slot == addr_a_s1) begin
				fwd_a_s1 <= wr_value;
			end
			if (wr_slot == addr_b_s1) begin
				fwd_b_s1 <= wr_value;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1 datapath: operand choice, saturating add and subtract, compare,
	// variable and constant copies, and the split of a multiply into four
	// products of 25 by 25 bits.
	// -----------------------------------------------------------------------
	always_comb begin
		opa = a_ok_s1 ? (fwd_a_vld_s1 ? fwd_a_s1 : rda_s1) : '0;
		opb = b_ok_s1 ? (fwd_b_vld_s1 ? fwd_b_s1 : rdb_s1) : '0;

		sum_s1  = wide_t'(opa) + wide_t'(opb);
		diff_s1 = wide_t'(opa) - wide_t'(opb);

		a_lo = {1'b0, opa[HALF_W-1:0]};
		a_hi = {opa[VALUE_W-1], opa[VALUE_W-1:HALF_W]};
		b_lo = {1'b0, opb[HALF_W-1:0]};
		b_hi = {opb[VALUE_W-1], opb[VALUE_W-1:HALF_W]};

		is_mul_s1 = 1'b0;
		val_s1    = '0;
		case (kind_s1)
			KIND_OP: begin
				case (code_s1)
					OP_ADD: val_s1 = sat_value(sum_s1);
					OP_SUB: val_s1 = sat_value(diff_s1);
					OP_MUL: is_mul_s1 = 1'b1;
					// On a tie both give the second operand, which is equal.
					OP_MAX: val_s1 = (opa > opb) ? opa : opb;
					OP_MIN: val_s1 = (opa < opb) ? opa : opb;
					default: val_s1 = '0;
				endcase
			end
			KIND_VAR: begin
				val_s1 = var_ok_s1 ? var_rd_s1 : '0;
			end
			KIND_CONST: begin
				case (code_s1[CFG_IDX_W-1:0])
					CFG_FIRST_CONST:  val_s1 = value_t'(cfg_q[0]);
					CFG_SECOND_CONST: val_s1 = value_t'(cfg_q[1]);
					CFG_THIRD_CONST:  val_s1 = value_t'(cfg_q[2]);
					default:          val_s1 = '0;
				endcase
				if (code_s1[CODE_W-1:CFG_IDX_W] != '0) begin
					val_s1 = '0;
				end
			end
			default: val_s1 = '0;
		endcase
	end

	// -----------------------------------------------------------------------
	// Stage 2 registers.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_go) begin
			vld_s2 <= 1'b1;
		end else if (s2_go) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			is_mul_s2 <= is_mul_s1;
			last_s2   <= last_s1;
			pos_s2    <= pos_s1;
			val_s2    <= val_s1;
			pp_ll_s2  <= a_lo * b_lo;
			pp_lh_s2  <= a_lo * b_hi;
			pp_hl_s2  <= a_hi * b_lo;
			pp_hh_s2  <= a_hi * b_hi;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 2 datapath: sum the partial products, drop the fraction bits with
	// an arithmetic shift (which rounds toward minus infinity) and clamp.
	// -----------------------------------------------------------------------
	always_comb begin
		prod = prod_t'(pp_ll_s2) +
		       (prod_t'(pp_lh_s2) <<< HALF_W) +
		       (prod_t'(pp_hl_s2) <<< HALF_W) +
		       (prod_t'(pp_hh_s2) <<< VALUE_W);
		prod_top = prod[PROD_W-1:FRAC_W+VALUE_W-1];
		if ((&prod_top) || !(|prod_top)) begin
			mul_value = prod[FRAC_W+VALUE_W-1:FRAC_W];
		end else begin
			mul_value = prod[PROD_W-1] ? Q_MIN : Q_MAX;
		end
	end

	// The slot is written as the result enters the result register.
	assign wr_en    = s2_go;
	assign wr_slot  = pos_s2;
	assign wr_value = is_mul_s2 ? mul_value : val_s2;

	// -----------------------------------------------------------------------
	// Result register.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s2_go) begin
			out_vld_q <= 1'b1;
		end else if (result_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_value_q <= wr_value;
			out_slot_q  <= GSLOT_W'(pos_s2);
			out_last_q  <= last_s2;
		end
	end

	assign result_valid = out_vld_q;
	assign gene_value   = out_value_q;
	assign gene_slot    = out_slot_q;
	assign is_output    = out_last_q;

	// -----------------------------------------------------------------------
	// Assertions.
	// -----------------------------------------------------------------------
	`ASSERT_PROP(a_last_restarts, clk, arst_n,
		(gene_go && last_gene) |=> (pos_q == '0), "last gene did not restart the position")
	`ASSERT_PROP(a_load_no_result, clk, arst_n,
		load_go |=> !vld_s1, "load transaction entered the gene pipeline")
	`ASSERT_PROP(a_fwd_capture_a, clk, arst_n,
		(vld_s1 && !s1_go && wr_en && (wr_slot == addr_a_s1)) |=> fwd_a_vld_s1,
		"slot write missed by a waiting first operand")
	`ASSERT_PROP(a_result_from_s2, clk, arst_n,
		$rose(out_vld_q) |-> $past(vld_s2), "result appeared without a stage 2 item")
	`ASSERT_NEVER(a_hazard_bypass, clk, arst_n,
		s1_go && vld_s2 && !s2_go && (kind_s1 == KIND_OP) &&
		(a_ok_s1 && (addr_a_s1 == pos_s2)),
		"gene moved past an unwritten operand slot")

endmodule

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// tb - testbench of linear_expression_program_evaluator
// Sends variable loads and genes over the valid/ready input channel and
// checks every gene value against a cycle-free model of the program store.
// The model keeps its own slot store, variable store, gene position and
// constants. Directed programs cover saturation, rounding, ties and the
// zero-valued codes. Random programs run under several idle and stall
// mixes, and one long receiver hold-off fills the pipeline.
// ---------------------------------------------------------------------------
module tb
	import lepe_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Run control.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 400;

	// Codes that the block accepts but treats as zero-valued.
	localparam int                   NUM_CONSTS = 3;
	localparam logic [KIND_W-1:0]    KIND_NONE  = 2'd3;
	localparam logic [CODE_W-1:0]    OP_NONE    = 4'd5;
	localparam logic [CODE_W-1:0]    CODE_TOP   = 4'd15;
	localparam logic [CODE_W-1:0]    CONST_NONE = 4'd3;

	// Register index of each constant, in the order of the constant codes.
	localparam logic [CFG_IDX_W-1:0] CONST_REG [NUM_CONSTS] =
		'{CFG_FIRST_CONST, CFG_SECOND_CONST, CFG_THIRD_CONST};

	localparam value_t Q_ONE = value_t'(65536);

	// One input transaction, field by field.
	typedef struct packed {
		logic                func;
		logic [VSLOT_W-1:0]  var_slot;
		value_t              var_value;
		logic [KIND_W-1:0]   gene_kind;
		logic [CODE_W-1:0]   gene_code;
		logic [SRC_W-1:0]    src_a;
		logic [SRC_W-1:0]    src_b;
		logic                last_gene;
	} item_t;

	// One gene result as the block should report it.
	typedef struct packed {
		value_t              value;
		logic [GSLOT_W-1:0]  slot;
		logic                is_out;
	} gene_result_t;

	// DUT ports.
	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CONST_W-1:0]        cfg_data;
	logic                      item_valid;
	logic                      item_ready;
	logic                      func;
	logic [VSLOT_W-1:0]        var_slot;
	logic signed [VALUE_W-1:0] var_value;
	logic [KIND_W-1:0]         gene_kind;
	logic [CODE_W-1:0]         gene_code;
	logic [SRC_W-1:0]          src_a;
	logic [SRC_W-1:0]          src_b;
	logic                      last_gene;
	logic                      result_valid;
	logic                      result_ready;
	logic signed [VALUE_W-1:0] gene_value;
	logic [GSLOT_W-1:0]        gene_slot;
	logic                      is_output;

	// Mirror of the program state and the gene values still to come back.
	value_t             slot_store [PROG_LEN_DEF];
	value_t             var_store [VAR_COUNT_DEF];
	value_t             const_regs [NUM_CONSTS];
	logic [GSLOT_W-1:0] next_slot;
	int                 slots_filled;
	gene_result_t       pending_genes [$];
	int                 error_count = 0;

	// Traffic shaping, changed by the test tasks between phases.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	linear_expression_program_evaluator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.func         (func),
		.var_slot     (var_slot),
		.var_value    (var_value),
		.gene_kind    (gene_kind),
		.gene_code    (gene_code),
		.src_a        (src_a),
		.src_b        (src_b),
		.last_gene    (last_gene),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.gene_value   (gene_value),
		.gene_slot    (gene_slot),
		.is_output    (is_output)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Gene arithmetic
	// ------------------------------------------------------------------

	// Clamp an exact result to the signed 48-bit range.
	function automatic value_t clamp_value(input prod_t x);
		if (x > prod_t'(Q_MAX)) begin
			return Q_MAX;
		end else if (x < prod_t'(Q_MIN)) begin
			return Q_MIN;
		end
		return value_t'(x);
	endfunction

	// Operators work on exact wide values. The product is floored by the
	// arithmetic shift, which matches rounding toward minus infinity.
	function automatic value_t apply_operator(input logic [CODE_W-1:0] code,
			input value_t a, input value_t b);
		prod_t product;
		product = prod_t'(a) * prod_t'(b);
		case (code)
			OP_ADD: return clamp_value(prod_t'(a) + prod_t'(b));
			OP_SUB: return clamp_value(prod_t'(a) - prod_t'(b));
			OP_MUL: return clamp_value(product >>> FRAC_W);
			// On a tie both pick the second operand, which is the same value.
			OP_MAX: return (a > b) ? a : b;
			OP_MIN: return (a < b) ? a : b;
			default: return '0;
		endcase
	endfunction

	// Advance the mirror by one accepted transaction. A load only updates
	// the variable store; a gene fills the next slot and owes one result.
	function automatic void evaluate_item(input item_t it);
		value_t       v;
		gene_result_t r;
		v = '0;
		if (it.func == FUNC_LOAD) begin
			if (it.var_slot < VAR_COUNT_DEF)
				var_store[it.var_slot] = it.var_value;
			return;
		end
		case (it.gene_kind)
			KIND_OP: v = apply_operator(it.gene_code, slot_store[it.src_a],
				slot_store[it.src_b]);
			KIND_VAR: begin
				if (it.gene_code < VAR_COUNT_DEF)
					v = var_store[it.gene_code];
			end
			KIND_CONST: begin
				if (it.gene_code < NUM_CONSTS)
					v = const_regs[it.gene_code];
			end
			default: v = '0;
		endcase
		r.value  = v;
		r.slot   = next_slot;
		r.is_out = it.last_gene;
		slot_store[next_slot] = v;
		if (int'(next_slot) + 1 > slots_filled)
			slots_filled = int'(next_slot) + 1;
		next_slot = it.last_gene ? '0 : next_slot + 1'b1;
		pending_genes.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Values lean toward small magnitudes so that programs do not all end
	// up saturated, with the extremes and full-width noise mixed in.
	function automatic value_t rand_value();
		int pick;
		int small_val;
		pick = $urandom_range(7);
		small_val = $urandom_range(1 << 20);
		small_val = small_val - (1 << 19);
		case (pick)
			0: return Q_MAX;
			1: return Q_MIN;
			2, 3: return value_t'({$urandom, $urandom});
			4: return value_t'($signed($urandom));
			default: return value_t'(small_val);
		endcase
	endfunction

	function automatic const_t rand_constant();
		int c;
		c = $urandom_range(131072);
		c = c - 65536;
		return const_t'(c);
	endfunction

	// Slots are always filled from zero upward, so every slot below
	// slots_filled holds a value and is safe to read.
	function automatic logic [SRC_W-1:0] pick_slot();
		if (slots_filled == 0)
			return SRC_W'($urandom_range(PROG_LEN_DEF - 1));
		return SRC_W'($urandom_range(slots_filled - 1));
	endfunction

	function automatic item_t make_gene(input logic [KIND_W-1:0] kind,
			input logic [CODE_W-1:0] code, input logic [SRC_W-1:0] a,
			input logic [SRC_W-1:0] b, input logic last);
		item_t it;
		it.func      = FUNC_GENE;
		it.var_slot  = VSLOT_W'($urandom_range(VAR_COUNT_DEF - 1));
		it.var_value = rand_value();
		it.gene_kind = kind;
		it.gene_code = code;
		it.src_a     = a;
		it.src_b     = b;
		it.last_gene = last;
		return it;
	endfunction

	// Mostly genes forming short programs, with some loads in between.
	function automatic item_t rand_item();
		item_t it;
		int    sel;
		sel = $urandom_range(19);
		it = make_gene(KIND_OP, OP_ADD, pick_slot(), pick_slot(),
			$urandom_range(7) == 0);
		if ($urandom_range(9) == 0)
			it.func = FUNC_LOAD;
		if (sel < 10) begin
			it.gene_kind = KIND_OP;
			it.gene_code = CODE_W'(($urandom_range(9) == 0) ? $urandom_range(CODE_TOP)
				: $urandom_range(OP_MIN));
		end else if (sel < 15) begin
			it.gene_kind = KIND_VAR;
			it.gene_code = CODE_W'($urandom_range(CODE_TOP));
		end else if (sel < 19) begin
			it.gene_kind = KIND_CONST;
			it.gene_code = CODE_W'(($urandom_range(7) == 0) ? $urandom_range(CODE_TOP)
				: $urandom_range(CONST_NONE));
		end else begin
			it.gene_kind = KIND_NONE;
			it.gene_code = CODE_W'($urandom_range(CODE_TOP));
		end
		// No operator gene may run before any slot holds a value.
		if (slots_filled == 0 && it.gene_kind == KIND_OP)
			it.gene_kind = KIND_VAR;
		return it;
	endfunction

	// Offer one transaction and hold it until the block takes it. Valid is
	// only lowered when an idle gap is inserted, so back-to-back
	// transactions never see valid dropped and raised in the same step.
	task automatic send_item(input item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func       <= it.func;
		var_slot   <= it.var_slot;
		var_value  <= it.var_value;
		gene_kind  <= it.gene_kind;
		gene_code  <= it.gene_code;
		src_a      <= it.src_a;
		src_b      <= it.src_b;
		last_gene  <= it.last_gene;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		evaluate_item(it);
	endtask

	// Stop offering and let every outstanding gene come back, then wait the
	// drain cycles; a load never enters the pipeline and owes no result.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_genes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three constants on consecutive edges; only called while
	// the block is idle.
	task automatic write_constants(input const_t c0, input const_t c1,
			input const_t c2);
		const_t vals [NUM_CONSTS];
		vals = '{c0, c1, c2};
		for (int i = 0; i < NUM_CONSTS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CONST_REG[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			const_regs[i] = value_t'(vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Load every variable once. The first few hold the values that the
	// operator test depends on; the rest get random contents.
	task automatic test_variable_loads();
		item_t it;
		value_t fixed [7];
		fixed = '{Q_MAX, Q_MIN, value_t'(0), Q_ONE, -Q_ONE, value_t'(-1),
			value_t'(3)};
		for (int v = 0; v < VAR_COUNT_DEF; v++) begin
			it = make_gene(KIND_VAR, CODE_W'(v), 0, 0, 1'b0);
			it.func = FUNC_LOAD;
			it.var_slot = VSLOT_W'(v);
			it.var_value = (v < 7) ? fixed[v] : rand_value();
			send_item(it);
		end
	endtask

	// Run more genes than there are slots without a last mark, so that the
	// position wraps, then close the program so the next one starts at 0.
	task automatic test_slot_wrap();
		item_t it;
		for (int n = 0; n < PROG_LEN_DEF + 6; n++) begin
			it = rand_item();
			it.func = FUNC_GENE;
			it.last_gene = 1'b0;
			send_item(it);
		end
		send_item(make_gene(KIND_CONST, CODE_W'(CFG_SECOND_CONST), 0, 0, 1'b1));
	endtask

	// One program that exercises saturation, multiply rounding, ties and
	// every zero-valued code. Slot numbers below are the gene positions.
	task automatic test_operators();
		send_item(make_gene(KIND_VAR, 4'd0, 0, 0, 1'b0)); // 0: max
		send_item(make_gene(KIND_VAR, 4'd1, 0, 0, 1'b0)); // 1: min
		send_item(make_gene(KIND_VAR, 4'd5, 0, 0, 1'b0)); // 2: -1 lsb
		send_item(make_gene(KIND_VAR, 4'd3, 0, 0, 1'b0)); // 3: one
		send_item(make_gene(KIND_VAR, 4'd4, 0, 0, 1'b0)); // 4: minus one
		send_item(make_gene(KIND_VAR, 4'd6, 0, 0, 1'b0)); // 5: 3 lsb
		send_item(make_gene(KIND_OP, OP_ADD, 0, 0, 1'b0));
		send_item(make_gene(KIND_OP, OP_SUB, 1, 0, 1'b0));
		send_item(make_gene(KIND_OP, OP_ADD, 1, 1, 1'b0));
		send_item(make_gene(KIND_OP, OP_SUB, 0, 1, 1'b0));
		send_item(make_gene(KIND_OP, OP_MUL, 0, 0, 1'b0));
		send_item(make_gene(KIND_OP, OP_MUL, 0, 1, 1'b0));
		// A tiny negative product must floor to -1, not truncate to 0.
		send_item(make_gene(KIND_OP, OP_MUL, 2, 5, 1'b0));
		send_item(make_gene(KIND_OP, OP_MUL, 3, 4, 1'b0));
		send_item(make_gene(KIND_OP, OP_MAX, 0, 1, 1'b0));
		send_item(make_gene(KIND_OP, OP_MIN, 0, 1, 1'b0));
		send_item(make_gene(KIND_OP, OP_MAX, 3, 3, 1'b0));
		send_item(make_gene(KIND_OP, OP_MIN, 2, 2, 1'b0));
		send_item(make_gene(KIND_OP, OP_NONE, 0, 1, 1'b0));
		send_item(make_gene(KIND_OP, CODE_TOP, 0, 1, 1'b0));
		send_item(make_gene(KIND_NONE, OP_ADD, 0, 1, 1'b0));
		// Constants still hold their reset value of zero here.
		send_item(make_gene(KIND_CONST, CODE_W'(CFG_FIRST_CONST), 0, 0, 1'b0));
		send_item(make_gene(KIND_CONST, CONST_NONE, 0, 0, 1'b0));
		send_item(make_gene(KIND_CONST, CODE_TOP, 0, 0, 1'b0));
		send_item(make_gene(KIND_OP, OP_ADD, 12, 13, 1'b1));
	endtask

	// Cycle the constants through three settings and read each one back.
	task automatic test_constant_settings();
		const_t sets [3][NUM_CONSTS];
		sets = '{'{-18'sd65536, 18'sd65536, 18'sd0},
			'{18'sd65536, -18'sd65536, -18'sd1},
			'{18'sd1, 18'sd0, 18'sd65535}};
		for (int s = 0; s < 3; s++) begin
			wait_idle();
			write_constants(sets[s][0], sets[s][1], sets[s][2]);
			for (int c = 0; c < NUM_CONSTS; c++)
				send_item(make_gene(KIND_CONST, CODE_W'(c), pick_slot(), pick_slot(),
					1'b0));
			send_item(make_gene(KIND_OP, OP_MUL, pick_slot(), pick_slot(), 1'b1));
		end
	endtask

	// Random programs under one idle/stall mix, with fresh constants.
	task automatic test_random(input int idle_pct, input int stall_pct);
		wait_idle();
		write_constants(rand_constant(), rand_constant(), rand_constant());
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_item(rand_item());
	endtask

	// Hold the result side off for a long stretch while genes keep coming,
	// so the pipeline fills and the block has to stall its input.
	task automatic test_backpressure();
		item_t it;
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = HOLD_CYCLES;
		for (int n = 0; n < 60; n++) begin
			it = rand_item();
			it.func = FUNC_GENE;
			send_item(it);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Receiver: stalls at random, or for a counted stretch when a
	// hold-off is requested.
	initial begin : result_sink
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every accepted result must match the oldest pending gene.
	always @(posedge clk) begin : check_results
		gene_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_genes.size() == 0) begin
				$error("unexpected result: slot %0d value %0d", gene_slot, gene_value);
				error_count++;
			end else begin
				want = pending_genes.pop_front();
				if (gene_value !== want.value) begin
					$error("gene_value: expected %0d, got %0d", want.value, gene_value);
					error_count++;
				end
				if (gene_slot !== want.slot) begin
					$error("gene_slot: expected %0d, got %0d", want.slot, gene_slot);
					error_count++;
				end
				if (is_output !== want.is_out) begin
					$error("is_output: expected %0d, got %0d", want.is_out, is_output);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction moves on either channel
	// for too long. The longest legal quiet stretch is the hold-off.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : main
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_FIRST_CONST;
		cfg_data   <= '0;
		item_valid <= 1'b0;
		func       <= FUNC_LOAD;
		var_slot   <= '0;
		var_value  <= '0;
		gene_kind  <= KIND_OP;
		gene_code  <= OP_ADD;
		src_a      <= '0;
		src_b      <= '0;
		last_gene  <= 1'b0;
		for (int i = 0; i < NUM_CONSTS; i++)
			const_regs[i] = '0;
		next_slot    = '0;
		slots_filled = 0;

		apply_reset();
		test_variable_loads();
		test_slot_wrap();
		test_operators();
		test_constant_settings();
		test_random(0, 0);
		test_random(84, 0);
		test_random(0, 84);
		test_random(33, 33);
		test_backpressure();
		wait_idle();

		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
